@@ hdl/csv_pkg.sv @@
// ----------------------------------------------------------------------------
// csv_pkg
// Shared types and constants for the quoted CSV field splitter.
// ----------------------------------------------------------------------------
package csv_pkg;

   // byte values with fixed meaning
   localparam logic [7:0] QuoteByte    = 8'h22;
   localparam logic [7:0] CrByte       = 8'h0D;
   localparam logic [7:0] LfByte       = 8'h0A;
   localparam logic [7:0] NulByte      = 8'h00;
   localparam logic [7:0] DelimReset   = 8'd44;

   // item kinds
   localparam logic KindByte = 1'b0;
   localparam logic KindEol  = 1'b1;

   // register file
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic        CsrIdxDelim  = 1'b0;

   // per-line parser flags
   typedef struct packed {
      logic in_quotes;
      logic quote_pending;
      logic field_nonempty;
      logic record_done;
   } line_state_type;

   // one result item
   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_out;
      logic       field_end;
      logic       record_end;
   } rsp_payload_type;

   // parser stage to output stage
   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } stage_result_type;

endpackage

@@ hdl/csv_req_if.sv @@
// ----------------------------------------------------------------------------
// csv_req_if
// Input channel: one line byte or end of line marker per transaction.
// ----------------------------------------------------------------------------
interface csv_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_in;

   modport source (output valid, output kind, output char_in, input ready);
   modport sink   (input valid, input kind, input char_in, output ready);
endinterface

@@ hdl/csv_rsp_if.sv @@
// ----------------------------------------------------------------------------
// csv_rsp_if
// Result channel: one field byte and/or field and record end flags.
// ----------------------------------------------------------------------------
interface csv_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [7:0] char_out;
   logic       field_end;
   logic       record_end;

   modport source (output valid, output char_valid, output char_out,
                   output field_end, output record_end, input ready);
   modport sink   (input valid, input char_valid, input char_out,
                   input field_end, input record_end, output ready);
endinterface

@@ hdl/csv_csr.sv @@
// ----------------------------------------------------------------------------
// csv_csr
// APB-style register file holding the delimiter byte.
// ----------------------------------------------------------------------------
module csv_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [csv_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [csv_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [csv_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready,
   output logic [7:0]                          delimiter
);

   logic [7:0] delim_ff;
   logic [7:0] delim_in;
   logic       reg_idx;
   logic       wr_en;

   // word index from byte address
   assign reg_idx = paddr[2];
   assign wr_en   = psel & penable & pwrite & (reg_idx == csv_pkg::CsrIdxDelim);
   assign pready  = 1'b1;

   assign delim_in = wr_en ? pwdata[7:0] : delim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= csv_pkg::DelimReset;
      end else begin
         delim_ff <= delim_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (reg_idx == csv_pkg::CsrIdxDelim) begin
         prdata = {{(csv_pkg::CsrDataWidth-8){1'b0}}, delim_ff};
      end
   end

   assign delimiter = delim_ff;

endmodule

@@ hdl/csv_parse.sv @@
// ----------------------------------------------------------------------------
// csv_parse
// Input register, per-line flags and the per-byte decision logic.
// ----------------------------------------------------------------------------
module csv_parse (
   input  logic                       clock,
   input  logic                       reset,
   csv_req_if.sink                    req,
   input  logic [7:0]                 delimiter,
   input  logic                       load_ok,
   output csv_pkg::stage_result_type  result
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic                    in_kind_ff;
   logic [7:0]              in_char_ff;
   logic                    advance;
   csv_pkg::line_state_type st_ff;
   csv_pkg::line_state_type st_in;
   csv_pkg::line_state_type st_calc;
   csv_pkg::rsp_payload_type pay;
   logic                    emit;

   // input register moves on whenever the output stage takes its result
   assign advance     = in_valid_ff & load_ok;
   assign req.ready   = ~in_valid_ff | load_ok;
   assign in_valid_in = req.ready ? req.valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid & req.ready) begin
         in_kind_ff <= req.kind;
         in_char_ff <= req.char_in;
      end
   end

   // per-byte decision
   always_comb begin
      logic iq;
      logic done;
      st_calc = st_ff;
      pay     = '0;
      emit    = 1'b0;
      iq      = st_ff.in_quotes;
      done    = 1'b0;
      if (in_kind_ff == csv_pkg::KindEol) begin
         st_calc        = '0;
         emit           = ~st_ff.record_done;
         pay.field_end  = 1'b1;
         pay.record_end = 1'b1;
      end else if (st_ff.record_done) begin
         emit = 1'b0;
      end else if (in_char_ff == csv_pkg::NulByte) begin
         st_calc             = '0;
         st_calc.record_done = 1'b1;
         emit                = 1'b1;
         pay.field_end       = 1'b1;
         pay.record_end      = 1'b1;
      end else begin
         // resolve a quote seen on the previous byte
         if (st_ff.quote_pending) begin
            st_calc.quote_pending = 1'b0;
            if (in_char_ff == csv_pkg::QuoteByte) begin
               st_calc.field_nonempty = 1'b1;
               emit                   = 1'b1;
               pay.char_valid         = 1'b1;
               pay.char_out           = csv_pkg::QuoteByte;
               done                   = 1'b1;
            end else begin
               iq                = 1'b0;
               st_calc.in_quotes = 1'b0;
            end
         end
         if (!done) begin
            if (!iq && !st_ff.field_nonempty && in_char_ff == csv_pkg::QuoteByte) begin
               st_calc.in_quotes = 1'b1;
            end else if (iq && in_char_ff == csv_pkg::QuoteByte) begin
               st_calc.quote_pending = 1'b1;
            end else if (!iq && in_char_ff == delimiter) begin
               st_calc.field_nonempty = 1'b0;
               emit                   = 1'b1;
               pay.field_end          = 1'b1;
            end else if (!iq && (in_char_ff == csv_pkg::CrByte ||
                                 in_char_ff == csv_pkg::LfByte)) begin
               st_calc.field_nonempty = 1'b0;
               st_calc.record_done    = 1'b1;
               emit                   = 1'b1;
               pay.field_end          = st_ff.field_nonempty;
               pay.record_end         = 1'b1;
            end else begin
               st_calc.field_nonempty = 1'b1;
               emit                   = 1'b1;
               pay.char_valid         = 1'b1;
               pay.char_out           = in_char_ff;
            end
         end
      end
   end

   // flags update as the item leaves the input register
   assign st_in = advance ? st_calc : st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign result.valid   = in_valid_ff & emit;
   assign result.payload = pay;

endmodule

@@ hdl/csv_out.sv @@
// ----------------------------------------------------------------------------
// csv_out
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module csv_out (
   input  logic                       clock,
   input  logic                       reset,
   input  csv_pkg::stage_result_type  result,
   output logic                       load_ok,
   csv_rsp_if.source                  rsp
);

   logic                     valid_ff;
   logic                     valid_in;
   csv_pkg::rsp_payload_type pay_ff;

   // register is free when empty or being drained this cycle
   assign load_ok  = ~valid_ff | rsp.ready;
   assign valid_in = load_ok ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok & result.valid) begin
         pay_ff <= result.payload;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.char_valid = pay_ff.char_valid;
   assign rsp.char_out   = pay_ff.char_out;
   assign rsp.field_end  = pay_ff.field_end;
   assign rsp.record_end = pay_ff.record_end;

endmodule

@@ hdl/csv_quoted_field_splitter_unit.sv @@
// An accepted input transaction passes through the input register, then the
// result register.
// Throughput: one transaction per cycle while the result side keeps up; the
// single-bit line flags are updated in the same cycle the byte is decided.
// Reset (synchronous, active high) empties both stages, clears the line flags
// and sets the delimiter to a comma.
// ----------------------------------------------------------------------------
// csv_quoted_field_splitter_unit
// Top level: CSV line splitter with quoted fields and a programmable delimiter.
// ----------------------------------------------------------------------------
module csv_quoted_field_splitter_unit (
   input  logic                                clock,
   input  logic                                reset,
   csv_req_if.sink                             req_if,
   csv_rsp_if.source                           rsp_if,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [csv_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [csv_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [csv_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready
);

   logic [7:0]                delimiter;
   logic                      load_ok;
   csv_pkg::stage_result_type result;

   csv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .delimiter (delimiter)
   );

   csv_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .delimiter (delimiter),
      .load_ok   (load_ok),
      .result    (result)
   );

   csv_out u_out (
      .clock   (clock),
      .reset   (reset),
      .result  (result),
      .load_ok (load_ok),
      .rsp     (rsp_if)
   );

endmodule

@@ verif/csv_quoted_field_splitter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// csv_quoted_field_splitter_unit_tb
// Self-checking bench for the quoted CSV field splitter. Drives line bytes and
// end of line markers over the request channel, predicts every result
// transaction with a behavioral line parser and checks each one field by
// field. It steps through several delimiter settings, extremes included, and
// idles and stalls both sides at random.
// ----------------------------------------------------------------------------
module csv_quoted_field_splitter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CycleLimit    = 400000;
   localparam int          ItemTarget    = 850;
   localparam int          NumSettings   = 9;
   localparam int          SettleCycles  = 8;
   localparam int          MaxGap        = 12;
   localparam int          MaxPrinted    = 50;
   localparam int          AddrW         = csv_pkg::CsrAddrWidth;
   localparam int          DataW         = csv_pkg::CsrDataWidth;
   localparam logic [AddrW-1:0] DelimAddr = AddrW'({csv_pkg::CsrIdxDelim, 2'b00});

   // -------------------------------------------------------------------------
   // Line parser prediction and result checking
   // -------------------------------------------------------------------------
   class csv_line_checker;
      logic [7:0]               delim;
      bit                       in_quotes;
      bit                       quote_pending;
      bit                       field_nonempty;
      bit                       record_done;
      csv_pkg::rsp_payload_type expected_q[$];
      int                       fail_count;

      function new();
         delim      = csv_pkg::DelimReset;
         fail_count = 0;
         clear_line();
      endfunction

      function void clear_line();
         in_quotes      = 1'b0;
         quote_pending  = 1'b0;
         field_nonempty = 1'b0;
         record_done    = 1'b0;
      endfunction

      function void set_delimiter(logic [7:0] d);
         delim = d;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // one accepted input transaction; queues the result it causes, if any
      function void note_input(logic kind, logic [7:0] ch);
         csv_pkg::rsp_payload_type r;
         bit                       emit;
         bit                       handled;
         r       = '0;
         emit    = 1'b0;
         handled = 1'b0;
         if (kind == csv_pkg::KindEol) begin
            emit         = !record_done;
            r.field_end  = 1'b1;
            r.record_end = 1'b1;
            clear_line();
         end else if (record_done) begin
            emit = 1'b0;   // rest of the line is dropped
         end else if (ch == csv_pkg::NulByte) begin
            clear_line();
            record_done  = 1'b1;
            emit         = 1'b1;
            r.field_end  = 1'b1;
            r.record_end = 1'b1;
         end else begin
            // a pending quote is settled by this byte
            if (quote_pending) begin
               quote_pending = 1'b0;
               if (ch == csv_pkg::QuoteByte) begin
                  field_nonempty = 1'b1;
                  emit           = 1'b1;
                  r.char_valid   = 1'b1;
                  r.char_out     = csv_pkg::QuoteByte;
                  handled        = 1'b1;
               end else begin
                  in_quotes = 1'b0;
               end
            end
            if (!handled) begin
               if (!in_quotes && !field_nonempty && ch == csv_pkg::QuoteByte) begin
                  in_quotes = 1'b1;
               end else if (in_quotes && ch == csv_pkg::QuoteByte) begin
                  quote_pending = 1'b1;
               end else if (!in_quotes && ch == delim) begin
                  field_nonempty = 1'b0;
                  emit           = 1'b1;
                  r.field_end    = 1'b1;
               end else if (!in_quotes && (ch == csv_pkg::CrByte ||
                                           ch == csv_pkg::LfByte)) begin
                  emit           = 1'b1;
                  r.field_end    = field_nonempty;
                  r.record_end   = 1'b1;
                  field_nonempty = 1'b0;
                  record_done    = 1'b1;
               end else begin
                  field_nonempty = 1'b1;
                  emit           = 1'b1;
                  r.char_valid   = 1'b1;
                  r.char_out     = ch;
               end
            end
         end
         if (emit) expected_q = {expected_q, r};
      endfunction

      task report(string msg);
         if (fail_count < MaxPrinted) $display("MISMATCH: %s", msg);
         fail_count++;
      endtask

      task check_result(csv_pkg::rsp_payload_type got);
         csv_pkg::rsp_payload_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing expected: %p", got));
         end else begin
            want = expected_q.pop_front();
            if (got.char_valid !== want.char_valid)
               report($sformatf("char_valid got %b want %b",
                                got.char_valid, want.char_valid));
            if (got.char_out !== want.char_out)
               report($sformatf("char_out got %h want %h",
                                got.char_out, want.char_out));
            if (got.field_end !== want.field_end)
               report($sformatf("field_end got %b want %b",
                                got.field_end, want.field_end));
            if (got.record_end !== want.record_end)
               report($sformatf("record_end got %b want %b",
                                got.record_end, want.record_end));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block
   // -------------------------------------------------------------------------
   logic             clock;
   logic             reset;
   logic             csr_psel;
   logic             csr_penable;
   logic             csr_pwrite;
   logic [AddrW-1:0] csr_paddr;
   logic [DataW-1:0] csr_pwdata;
   logic [DataW-1:0] csr_prdata;
   logic             csr_pready;

   csv_req_if req_bus ();
   csv_rsp_if rsp_bus ();

   csv_line_checker checker_h;
   int              cycle_count;
   int              items_done;
   bit              tx_burst;
   bit              rx_burst;

   csv_quoted_field_splitter_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run length guard
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // one input transaction; valid is only lowered when a gap follows
   task automatic send_item(input logic kind, input logic [7:0] ch);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.kind    <= kind;
      req_bus.char_in <= ch;
      do @(posedge clock); while (!req_bus.ready);
      if (kind == csv_pkg::KindEol || !checker_h.record_done) items_done++;
      checker_h.note_input(kind, ch);
   endtask

   // sender holds off until every expected result is in and the pipe is empty
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (checker_h.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [AddrW-1:0] addr,
                            input logic [DataW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == DelimAddr) checker_h.set_delimiter(data[7:0]);
      @(posedge clock);
   endtask

   // one content byte of a field; a quote inside quotes goes out doubled
   task automatic send_content(input bit quoted);
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);
            if (quoted) send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);
         end
         1: send_item(csv_pkg::KindByte,
                      quoted ? checker_h.delim : 8'($urandom_range(0, 255)));
         2: send_item(csv_pkg::KindByte,
                      quoted ? ($urandom_range(0, 1) ? csv_pkg::CrByte : csv_pkg::LfByte)
                             : 8'($urandom_range(0, 255)));
         3: send_item(csv_pkg::KindByte, 8'($urandom_range(0, 255)));
         default: send_item(csv_pkg::KindByte, 8'($urandom_range(8'h20, 8'h7e)));
      endcase
   endtask

   // a line of random fields and content, then its terminator
   task automatic send_line();
      int   n_fields;
      int   len;
      int   term;
      bit   quoted;
      tx_burst = ($urandom_range(0, 3) == 0);
      n_fields = $urandom_range(1, 5);
      for (int f = 0; f < n_fields; f++) begin
         if (f > 0) send_item(csv_pkg::KindByte, checker_h.delim);
         quoted = ($urandom_range(0, 2) == 0);
         len    = $urandom_range(0, 6);
         if (quoted) send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);
         for (int i = 0; i < len; i++) send_content(quoted);
         if (quoted) send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);
      end
      term = $urandom_range(0, 4);
      case (term)
         0: send_item(csv_pkg::KindByte, csv_pkg::CrByte);
         1: send_item(csv_pkg::KindByte, csv_pkg::LfByte);
         2: send_item(csv_pkg::KindByte, csv_pkg::NulByte);
         3: begin
            send_item(csv_pkg::KindByte, csv_pkg::CrByte);
            send_item(csv_pkg::KindByte, csv_pkg::LfByte);
         end
         default: ;   // marker alone closes the line
      endcase
      // trailing bytes after the record end are dropped
      repeat ($urandom_range(0, 2)) send_item(csv_pkg::KindByte, 8'($urandom_range(0, 255)));
      send_item(csv_pkg::KindEol, 8'($urandom_range(0, 255)));
   endtask

   // unstructured items, biased toward bytes with special meaning
   task automatic send_noise();
      logic [7:0] ch;
      tx_burst = ($urandom_range(0, 1) == 0);
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 7))
            0: ch = csv_pkg::QuoteByte;
            1: ch = checker_h.delim;
            2: ch = $urandom_range(0, 1) ? csv_pkg::CrByte : csv_pkg::LfByte;
            3: ch = csv_pkg::NulByte;
            default: ch = 8'($urandom_range(0, 255));
         endcase
         send_item(($urandom_range(0, 7) == 0) ? csv_pkg::KindEol : csv_pkg::KindByte, ch);
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: random stalls, with burst stretches
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      rx_burst = 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, MaxGap);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         checker_h.check_result('{rsp_bus.char_valid, rsp_bus.char_out,
                                  rsp_bus.field_end, rsp_bus.record_end});
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [7:0] delim_plan [NumSettings];
      int         target;
      checker_h  = new();
      items_done = 0;
      tx_burst   = 1'b0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.kind    <= csv_pkg::KindByte;
      req_bus.char_in <= 8'h00;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: comma delimiter from reset
      send_item(csv_pkg::KindEol, 8'hFF);                  // empty line
      send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);    // "a""b",c CR z
      send_item(csv_pkg::KindByte, 8'h61);
      send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);
      send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);    // doubled quote
      send_item(csv_pkg::KindByte, 8'h62);
      send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);    // pending, closed by comma
      send_item(csv_pkg::KindByte, csv_pkg::DelimReset);
      send_item(csv_pkg::KindByte, 8'h63);
      send_item(csv_pkg::KindByte, csv_pkg::CrByte);
      send_item(csv_pkg::KindByte, 8'h7A);                 // ignored after record end
      send_item(csv_pkg::KindEol, 8'h00);                  // nothing after record end
      send_item(csv_pkg::KindByte, 8'h78);                 // x" with 0xFF then NUL
      send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);    // quote in non-empty field
      send_item(csv_pkg::KindByte, 8'hFF);
      send_item(csv_pkg::KindByte, csv_pkg::NulByte);
      send_item(csv_pkg::KindEol, 8'h80);
      send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);    // ",LF" then pending at marker
      send_item(csv_pkg::KindByte, csv_pkg::DelimReset);
      send_item(csv_pkg::KindByte, csv_pkg::LfByte);
      send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);
      send_item(csv_pkg::KindEol, 8'h55);
      send_item(csv_pkg::KindByte, csv_pkg::QuoteByte);    // NUL inside quotes
      send_item(csv_pkg::KindByte, csv_pkg::NulByte);
      send_item(csv_pkg::KindEol, 8'hAA);

      // random lines under several delimiter settings
      delim_plan = '{csv_pkg::DelimReset, 8'h00, 8'hFF, csv_pkg::QuoteByte,
                     csv_pkg::CrByte, csv_pkg::LfByte, 8'h3B, 8'h09,
                     8'($urandom_range(0, 255))};
      target = items_done;
      for (int p = 0; p < NumSettings; p++) begin
         drain_results();
         csr_write(DelimAddr, {24'($urandom), delim_plan[p]});
         target += ItemTarget / NumSettings;
         while (items_done < target) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_line();
            if ($urandom_range(0, 39) == 0) drain_results();
         end
      end

      // wind down
      drain_results();
      if (checker_h.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
